[sv/fasta_soft_mask_extractor_unit_macros.svh]
// ----------------------------------------------------------------------------
// FASTA soft-mask extractor assertion macros
// Concurrent assertion shorthands for the checker, clocked with reset disable.
// ----------------------------------------------------------------------------
`ifndef FASTA_SOFT_MASK_EXTRACTOR_UNIT_MACROS_SVH
`define FASTA_SOFT_MASK_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication
`define FSME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsme assertion failed");

// next-cycle implication
`define FSME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsme assertion failed");

`endif

[sv/fsme_pkg.sv]
// ----------------------------------------------------------------------------
// fsme_pkg
// Shared constants, phase encoding and transaction structs.
// ----------------------------------------------------------------------------
package fsme_pkg;

  localparam int COUNT_WIDTH_DEF = 40;
  localparam int RUN_W           = 40;

  localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_LF   = 8'h0A;  // newline
  localparam logic [7:0] SPACE_MAX = 8'd32;  // control and blank bytes
  localparam logic [7:0] LOWER_MIN = 8'd96;  // lowercase threshold
  localparam logic [7:0] CASE_MASK = 8'hDF;  // clears the case bit

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_SEQ    = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [RUN_W-1:0] run_length;
    logic             run_valid;
    logic             format_error;
  } result_t;

endpackage

[sv/fsme_in_reg.sv]
// ----------------------------------------------------------------------------
// fsme_in_reg
// Input register stage; holds one transaction until the core takes it.
// ----------------------------------------------------------------------------
module fsme_in_reg
  import fsme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  input  logic       adv,
  output logic       item_vld,
  output in_item_t   item
);

  logic     item_vld_r;
  in_item_t item_r;

  assign in_stall = item_vld_r & ~adv;
  assign item_vld = item_vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.data_byte     <= in_data_byte;
      item_r.end_of_stream <= in_end_of_stream;
    end
  end

endmodule

[sv/fsme_core.sv]
// ----------------------------------------------------------------------------
// fsme_core
// Parser state, mask flag and run counter with the per-byte result logic.
// ----------------------------------------------------------------------------
module fsme_core
  import fsme_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output result_t  res
);

  phase_t                 phase_r, phase_nxt;
  logic                   mask_r, mask_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] cnt_base;
  logic                   lower;
  logic [7:0]             b;

  assign b     = item.data_byte;
  assign lower = (b >= LOWER_MIN);

  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    count_nxt = count_r;
    cnt_base  = count_r;
    res       = '0;
    if (phase_r == PH_ERROR) begin
      // sticky error: everything ignored
    end else if (item.end_of_stream) begin
      res.run_valid  = (count_r != '0);
      res.run_length = (count_r != '0) ? RUN_W'(count_r) : '0;
      phase_nxt      = PH_START;
      mask_nxt       = 1'b0;
      count_nxt      = '0;
    end else begin
      case (phase_r)
        PH_START: begin
          if (b == CHAR_GT) begin
            res.out_byte   = b;
            res.byte_valid = 1'b1;
            phase_nxt      = PH_HEADER;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_HEADER: begin
          res.out_byte   = b;
          res.byte_valid = 1'b1;
          if (b == CHAR_LF) begin
            phase_nxt = PH_SEQ;
          end
        end
        PH_SEQ: begin
          res.byte_valid = 1'b1;
          if (b == CHAR_GT) begin
            res.out_byte = b;
            phase_nxt    = PH_HEADER;
          end else if (b <= SPACE_MAX) begin
            res.out_byte = b;
          end else begin
            if (lower != mask_r) begin
              // case change closes the current run
              res.run_valid  = 1'b1;
              res.run_length = RUN_W'(count_r);
              mask_nxt       = lower;
              cnt_base       = '0;
            end
            res.out_byte = b & CASE_MASK;
            count_nxt    = (cnt_base == {COUNT_WIDTH{1'b1}}) ? cnt_base
                                                             : cnt_base + COUNT_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
    res.format_error = (phase_nxt == PH_ERROR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      mask_r  <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[sv/fsme_out_reg.sv]
// ----------------------------------------------------------------------------
// fsme_out_reg
// Result register; frees itself whenever the consumer takes the transaction.
// ----------------------------------------------------------------------------
module fsme_out_reg
  import fsme_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_vld,
  input  result_t                res,
  output logic                   adv,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_out_byte,
  output logic                   out_byte_valid,
  output logic [RUN_W-1:0]       out_run_length,
  output logic                   out_run_valid,
  output logic                   out_format_error
);

  logic    out_vld_r;
  result_t res_r;

  assign adv              = ~out_vld_r | ~out_stall;
  assign out_valid        = out_vld_r;
  assign out_out_byte     = res_r.out_byte;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_run_length   = res_r.run_length;
  assign out_run_valid    = res_r.run_valid;
  assign out_format_error = res_r.format_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

endmodule

[sv/fasta_soft_mask_extractor_unit.sv]
// ----------------------------------------------------------------------------
// fasta_soft_mask_extractor_unit: FASTA soft-mask run extraction, top level
// Each accepted byte waits in the input register; its result moves to the
// result register once that is free; 1 byte per cycle while out_stall is low.
// Throughput set by the state update in fsme_core.
// Synchronous active-low reset clears phase, mask flag, count and valids.
// ----------------------------------------------------------------------------
//
// Data path:
//   in_*  -> fsme_in_reg (input register)
//         -> fsme_core   (phase / mask / run count, one step per transaction)
//         -> fsme_out_reg (result register) -> out_*
//
// Every accepted transaction yields exactly one result transaction. The core
// advances only when the result register can take the new result, so the
// parser state always matches the results already produced. in_stall rises
// only when both registers are occupied and the consumer is stalling.
//
// Header bytes pass unchanged, sequence letters come out uppercased and their
// case runs are reported as alternating unmasked/masked lengths. A bad first
// byte sets a sticky format error; end of stream flushes the open run and
// returns the parser to its start state.
module fasta_soft_mask_extractor_unit
  import fsme_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_stream,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_byte_valid,
  output logic [RUN_W-1:0] out_run_length,
  output logic             out_run_valid,
  output logic             out_format_error
);

  logic     adv;       // result register can take a result this cycle
  logic     item_vld;  // input register holds a transaction
  in_item_t item;
  result_t  res;

  fsme_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .adv              (adv),
    .item_vld         (item_vld),
    .item             (item)
  );

  // state commits exactly when the held transaction moves to the output
  fsme_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (item_vld & adv),
    .item  (item),
    .res   (res)
  );

  fsme_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_vld          (item_vld),
    .res              (res),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_run_length   (out_run_length),
    .out_run_valid    (out_run_valid),
    .out_format_error (out_format_error)
  );

endmodule

[sv/fsme_checker.sv]
// ----------------------------------------------------------------------------
// fsme_checker
// Port-level checks on results of the soft-mask extractor, bound to the top.
// ----------------------------------------------------------------------------
`include "fasta_soft_mask_extractor_unit_macros.svh"

module fsme_checker
  import fsme_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_out_byte,
  input logic             out_byte_valid,
  input logic [RUN_W-1:0] out_run_length,
  input logic             out_run_valid,
  input logic             out_format_error
);

  logic err_seen_r;  // an error result has been delivered since reset

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_format_error) begin
      err_seen_r <= 1'b1;
    end
  end

  `FSME_ASSERT_IMP(a_err_sticky, clk, rst_n, out_valid && err_seen_r, out_format_error)
  `FSME_ASSERT_IMP(a_err_silent, clk, rst_n, out_valid && out_format_error, !out_byte_valid && !out_run_valid)
  `FSME_ASSERT_IMP(a_byte_zero, clk, rst_n, out_valid && !out_byte_valid, out_out_byte == 8'd0)
  `FSME_ASSERT_IMP(a_run_zero, clk, rst_n, out_valid && !out_run_valid, out_run_length == '0)
  `FSME_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_run_length))

endmodule

bind fasta_soft_mask_extractor_unit fsme_checker u_fsme_checker (.*);
